>>> src/nav_subframe_framer_assert.svh
// Assertion macros shared by the framer RTL.
`ifndef NAV_SUBFRAME_FRAMER_ASSERT_SVH
`define NAV_SUBFRAME_FRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition must hold on every clock edge out of reset.
`define NSF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("framer assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define NSF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");
`else
`define NSF_ASSERT_ALWAYS(lbl, cond)
`define NSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/nsf_pkg.sv
// Package with constants, types and the word parity function of the framer.
`timescale 1ns / 1ps
package nsf_pkg;
	localparam int RING_BITS      = 512;
	localparam int RING_AW        = $clog2(RING_BITS);
	localparam int MAX_PENDING    = 16;
	localparam int PEND_AW        = $clog2(MAX_PENDING);
	localparam int PEND_CW        = $clog2(MAX_PENDING + 1);
	localparam int SUBFRAME_BITS  = 300;
	localparam int WORD_BITS      = 30;
	localparam int WORDS          = 10;
	localparam int SCAN_CW        = $clog2(SUBFRAME_BITS + 1);
	localparam int WIDX_W         = 4;
	localparam int BIDX_W         = 5;
	localparam logic [7:0] PREAMBLE_RESET = 8'h8b;
	localparam logic REG_PREAMBLE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	// IS-GPS-200 parity check; p29 and p30 are D29* and D30* of the previous word.
	function automatic logic word_ok(input logic [29:0] w, input logic p29, input logic p30);
		logic [1:24] d;
		logic [5:0] p;
		d = w[29:6] ^ {24{p30}};
		p[5] = p29 ^ d[1] ^ d[2] ^ d[3] ^ d[5] ^ d[6] ^ d[10] ^ d[11] ^ d[12] ^ d[13]
			^ d[14] ^ d[17] ^ d[18] ^ d[20] ^ d[23];
		p[4] = p30 ^ d[2] ^ d[3] ^ d[4] ^ d[6] ^ d[7] ^ d[11] ^ d[12] ^ d[13] ^ d[14]
			^ d[15] ^ d[18] ^ d[19] ^ d[21] ^ d[24];
		p[3] = p29 ^ d[1] ^ d[3] ^ d[4] ^ d[5] ^ d[7] ^ d[8] ^ d[12] ^ d[13] ^ d[14]
			^ d[15] ^ d[16] ^ d[19] ^ d[20] ^ d[22];
		p[2] = p30 ^ d[2] ^ d[4] ^ d[5] ^ d[6] ^ d[8] ^ d[9] ^ d[13] ^ d[14] ^ d[15]
			^ d[16] ^ d[17] ^ d[20] ^ d[21] ^ d[23];
		p[1] = p30 ^ d[1] ^ d[3] ^ d[5] ^ d[6] ^ d[7] ^ d[9] ^ d[10] ^ d[14] ^ d[15]
			^ d[16] ^ d[17] ^ d[18] ^ d[21] ^ d[22] ^ d[24];
		p[0] = p29 ^ d[3] ^ d[5] ^ d[6] ^ d[8] ^ d[9] ^ d[10] ^ d[11] ^ d[13] ^ d[15]
			^ d[19] ^ d[22] ^ d[23] ^ d[24];
		return (p == w[5:0]);
	endfunction
endpackage

>>> src/nsf_if.sv
// Request channel interfaces for navigation bits in and subframe words out.
`timescale 1ns / 1ps
interface nsf_bit_if;
	logic        valid;
	logic        ready;
	logic        nav_bit;
	logic [31:0] sample_time;
	modport source (output valid, nav_bit, sample_time, input ready);
	modport sink (input valid, nav_bit, sample_time, output ready);
endinterface

interface nsf_word_if;
	logic        valid;
	logic        ready;
	logic [3:0]  word_index;
	logic [29:0] word_bits;
	logic [31:0] start_time;
	logic        was_inverted;
	logic        last_word;
	modport source (output valid, word_index, word_bits, start_time, was_inverted, last_word,
		input ready);
	modport sink (input valid, word_index, word_bits, start_time, was_inverted, last_word,
		output ready);
endinterface

>>> src/nav_subframe_framer.sv
// Top level of the navigation subframe framer: preamble search, ring, parity, word output.
// A bit that completes a subframe yields its first word once check has passed and the 300 ring
// reads through the single RAM read port are done and the words have passed parity.
// A bit with no mature candidate passes through idle and check; a maturing candidate also takes
// the ring scan and, if parity holds, 10 output requests. The block takes no bit meanwhile.
// Reset (arst_n low, asynchronous) clears sequencer, pointers, recent bits; preamble is 0x8b.
`timescale 1ns / 1ps
`include "nav_subframe_framer_assert.svh"
module nav_subframe_framer
	import nsf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	nsf_bit_if.sink       bit_in,
	nsf_word_if.source    word_out,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	state_t state_q;

	logic [7:0]         preamble_q;
	logic [RING_AW-1:0] write_pos_q;
	logic [7:0]         recent_q;
	logic [31:0]        times_q [8];

	// Pending candidate queue; entries carry no reset.
	logic [RING_AW-1:0] pend_start_q [MAX_PENDING];
	logic               pend_flip_q [MAX_PENDING];
	logic [31:0]        pend_time_q [MAX_PENDING];
	logic [PEND_AW-1:0] pend_head_q;
	logic [PEND_CW-1:0] pend_count_q;

	// Scan and emit state for the candidate being worked on.
	logic [RING_AW-1:0] rd_addr_q;
	logic [SCAN_CW-1:0] issue_cnt_q;
	logic               rvld_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [BIDX_W-1:0]  bit_cnt_q;
	logic [WIDX_W-1:0]  word_cnt_q;
	logic               good_q;
	logic               p29_q;
	logic               p30_q;
	logic [WORD_BITS-1:0] words_q [WORDS];
	logic [31:0]        cur_time_q;
	logic               cur_flip_q;
	logic [WIDX_W-1:0]  emit_q;

	logic               ring_rdata;
	logic               bit_acc;
	logic               out_acc;
	logic               cfg_wr;
	logic [7:0]         new_recent;
	logic               match;
	logic [PEND_AW-1:0] push_slot;
	logic [RING_AW-1:0] gap;
	logic               mature;
	logic               issuing;
	logic [WORD_BITS-1:0] acc_next;
	logic               word_end;
	logic               scan_end;
	logic               word_good;

	assign bit_in.ready = (state_q == ST_IDLE);
	assign bit_acc      = bit_in.valid && bit_in.ready;
	assign out_acc      = word_out.valid && word_out.ready;

	// APB: one register, always ready, writes land in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_PREAMBLE) ? {24'd0, preamble_q} : 32'd0;

	// Preamble search on the bit being accepted.
	assign new_recent = {recent_q[6:0], bit_in.nav_bit};
	assign match      = (new_recent == preamble_q) || ((new_recent ^ 8'hff) == preamble_q);
	assign push_slot  = pend_head_q + pend_count_q[PEND_AW-1:0];

	// Modular distance from the oldest candidate's start to the write pointer.
	assign gap    = write_pos_q - pend_start_q[pend_head_q];
	assign mature = (pend_count_q != '0) && ({1'b0, gap} >= (RING_AW + 1)'(SUBFRAME_BITS));

	assign issuing   = (state_q == ST_SCAN) && (issue_cnt_q != SCAN_CW'(SUBFRAME_BITS));
	assign acc_next  = {acc_q[WORD_BITS-2:0], ring_rdata ^ cur_flip_q};
	assign word_end  = rvld_q && (bit_cnt_q == BIDX_W'(WORD_BITS - 1));
	assign scan_end  = word_end && (word_cnt_q == WIDX_W'(WORDS - 1));
	assign word_good = word_ok(acc_next, p29_q, p30_q);

	nsf_ram #(
		.WIDTH (1),
		.DEPTH (RING_BITS)
	) u_ring (
		.clk   (clk),
		.we    (bit_acc),
		.waddr (write_pos_q),
		.wdata (bit_in.nav_bit),
		.raddr (rd_addr_q),
		.rdata (ring_rdata)
	);

	// Sequencer: idle takes a bit, check looks at the oldest candidate, scan reads
	// 300 bits one per cycle through the RAM port and checks each word as it completes,
	// emit hands out the ten words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			preamble_q   <= PREAMBLE_RESET;
			write_pos_q  <= '0;
			recent_q     <= '0;
			pend_head_q  <= '0;
			pend_count_q <= '0;
			issue_cnt_q  <= '0;
			rvld_q       <= 1'b0;
			bit_cnt_q    <= '0;
			word_cnt_q   <= '0;
			emit_q       <= '0;
			for (int i = 0; i < 8; i++) begin
				times_q[i] <= '0;
			end
		end else begin
			if (cfg_wr && (paddr[2] == REG_PREAMBLE)) begin
				preamble_q <= pwdata[7:0];
			end
			rvld_q <= issuing;
			unique case (state_q)
				ST_IDLE: begin
					if (bit_acc) begin
						write_pos_q <= write_pos_q + 1'b1;
						recent_q    <= new_recent;
						times_q[0]  <= bit_in.sample_time;
						for (int i = 1; i < 8; i++) begin
							times_q[i] <= times_q[i-1];
						end
						if (match && (pend_count_q != PEND_CW'(MAX_PENDING))) begin
							pend_count_q <= pend_count_q + 1'b1;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					issue_cnt_q <= '0;
					bit_cnt_q   <= '0;
					word_cnt_q  <= '0;
					state_q     <= mature ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (issuing) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (rvld_q) begin
						bit_cnt_q <= word_end ? '0 : bit_cnt_q + 1'b1;
					end
					if (word_end) begin
						word_cnt_q <= word_cnt_q + 1'b1;
					end
					if (scan_end) begin
						pend_head_q  <= pend_head_q + 1'b1;
						pend_count_q <= pend_count_q - 1'b1;
						emit_q       <= '0;
						state_q      <= (good_q && word_good) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == WIDX_W'(WORDS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (bit_acc && match && (pend_count_q != PEND_CW'(MAX_PENDING))) begin
			pend_start_q[push_slot] <= write_pos_q - RING_AW'(7);
			pend_flip_q[push_slot]  <= (new_recent != preamble_q);
			pend_time_q[push_slot]  <= times_q[6];
		end
		if (state_q == ST_CHECK) begin
			rd_addr_q  <= pend_start_q[pend_head_q];
			cur_time_q <= pend_time_q[pend_head_q];
			cur_flip_q <= pend_flip_q[pend_head_q];
			good_q     <= 1'b1;
			p29_q      <= 1'b0;
			p30_q      <= 1'b0;
		end
		if (issuing) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (rvld_q) begin
			acc_q <= acc_next;
		end
		if (word_end) begin
			words_q[word_cnt_q] <= acc_next;
			good_q <= good_q && word_good;
			p29_q  <= acc_next[1];
			p30_q  <= acc_next[0];
		end
	end

	assign word_out.valid        = (state_q == ST_EMIT);
	assign word_out.word_index   = emit_q;
	assign word_out.word_bits    = words_q[emit_q];
	assign word_out.start_time   = cur_time_q;
	assign word_out.was_inverted = cur_flip_q;
	assign word_out.last_word    = (emit_q == WIDX_W'(WORDS - 1));

	`NSF_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q))
	`NSF_ASSERT_ALWAYS(a_count_bound, pend_count_q <= PEND_CW'(MAX_PENDING))
	`NSF_ASSERT_NEXT(a_pop_on_scan_end, (state_q == ST_SCAN) && scan_end,
		pend_count_q == $past(pend_count_q) - 1'b1)
	`NSF_ASSERT_ALWAYS(a_emit_index, (state_q != ST_EMIT) || (emit_q < WIDX_W'(WORDS)))
	`NSF_ASSERT_NEXT(a_scan_needs_candidate, (state_q == ST_CHECK) && mature,
		(state_q == ST_SCAN) && (pend_count_q != '0))
endmodule

>>> src/nsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nsf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> verif/nav_subframe_framer_test.sv
// Self-checking testbench for the navigation subframe framer.
`timescale 1ns / 1ps
module nav_subframe_framer_test;
	import nsf_pkg::*;

	// Words from the bit stream that the framer must emit, oldest first.
	typedef struct packed {
		logic [3:0]  idx;
		logic [29:0] bits;
		logic [31:0] st;
		logic        inv;
		logic        last;
	} nav_word_t;

	typedef struct packed {
		logic        b;
		logic [31:0] t;
	} nav_bit_t;

	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE      = 400;

	// Parity masks over d1..d24, d1 in bit 23, for D25..D30 in that order.
	localparam logic [23:0] PAR_MASK [6] = '{24'hEC7CD2, 24'h763E69, 24'hBB1F34,
		24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27};
	// D25, D27 and D30 fold in D29* of the previous word; the rest fold in D30*.
	localparam logic [5:0] USE_P29 = 6'b101001;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	nsf_bit_if  bit_in ();
	nsf_word_if word_out ();

	nav_subframe_framer uut (
		.clk(clk), .arst_n(arst_n), .bit_in(bit_in.sink), .word_out(word_out.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Shadow copy of the framer state used to predict the emitted words.
	logic        ring_bits [RING_BITS];
	logic [8:0]  wr_pos;
	logic [7:0]  last8;
	logic [31:0] last8_times [8];
	logic [8:0]  cand_start [MAX_PENDING];
	logic        cand_flip [MAX_PENDING];
	logic [31:0] cand_time [MAX_PENDING];
	logic [3:0]  cand_head;
	logic [4:0]  cand_count;
	logic [7:0]  sync_pattern;

	nav_bit_t  bit_queue [$];
	nav_word_t words_due [$];

	int  send_idle, recv_idle;
	logic recv_hold;
	logic bit_taken;
	int  mismatches, bits_taken, words_taken, quiet;
	int  phase;

	// Six parity bits of a word, computed from its source data bits.
	function automatic logic [5:0] parity_of(logic [23:0] d, logic p29, logic p30);
		logic [5:0] p;
		for (int k = 0; k < 6; k++)
			p[5 - k] = (USE_P29[5 - k] ? p29 : p30) ^ (^(d & PAR_MASK[k]));
		return p;
	endfunction

	function automatic logic parity_good(logic [29:0] w, logic p29, logic p30);
		return parity_of(w[29:6] ^ {24{p30}}, p29, p30) == w[5:0];
	endfunction

	// Advances the shadow state by one accepted bit and queues any words it completes.
	task automatic framer_predict(logic b, logic [31:0] t);
		logic [3:0] slot;
		logic [8:0] span, s;
		logic [29:0] w [WORDS];
		logic good, p29, p30;
		ring_bits[wr_pos] = b;
		wr_pos = wr_pos + 9'd1;
		last8 = {last8[6:0], b};
		for (int k = 7; k > 0; k--)
			last8_times[k] = last8_times[k - 1];
		last8_times[0] = t;
		if ((last8 == sync_pattern || ~last8 == sync_pattern) && cand_count < MAX_PENDING) begin
			slot = cand_head + cand_count[3:0];
			cand_start[slot] = wr_pos - 9'd8;
			cand_flip[slot] = (last8 != sync_pattern);
			cand_time[slot] = last8_times[7];
			cand_count++;
		end
		if (cand_count > 0) begin
			span = wr_pos - cand_start[cand_head];
			if (span >= SUBFRAME_BITS) begin
				good = 1'b1;
				p29 = 1'b0;
				p30 = 1'b0;
				s = cand_start[cand_head];
				for (int i = 0; i < WORDS; i++) begin
					for (int j = 0; j < WORD_BITS; j++) begin
						w[i] = {w[i][28:0], ring_bits[s]};
						s = s + 9'd1;
					end
					if (cand_flip[cand_head])
						w[i] = ~w[i];
					if (!parity_good(w[i], p29, p30))
						good = 1'b0;
					p29 = w[i][1];
					p30 = w[i][0];
				end
				if (good) begin
					for (int i = 0; i < WORDS; i++)
						words_due.insert(words_due.size(), '{idx: i[3:0], bits: w[i],
							st: cand_time[cand_head], inv: cand_flip[cand_head],
							last: (i == WORDS - 1)});
				end
				cand_head = cand_head + 4'd1;
				cand_count--;
			end
		end
	endtask

	task automatic queue_bit(logic b, logic [31:0] t);
		bit_queue.insert(bit_queue.size(), '{b: b, t: t});
	endtask

	task automatic queue_noise(int n);
		for (int i = 0; i < n; i++)
			queue_bit(1'($urandom_range(1)), $urandom);
	endtask

	// Queues one subframe with valid parity; a nonzero corrupt flips one bit so it fails.
	task automatic queue_subframe(logic [7:0] pat, logic inv, logic [31:0] t0, bit corrupt);
		logic [23:0] d;
		logic [29:0] w;
		logic p29, p30;
		int bad_pos, n;
		p29 = 1'b0;
		p30 = 1'b0;
		n = 0;
		bad_pos = $urandom_range(299, 8);
		for (int i = 0; i < WORDS; i++) begin
			d = 24'($urandom);
			if (i == 0)
				d[23:16] = pat;
			w = {d ^ {24{p30}}, parity_of(d, p29, p30)};
			p29 = w[1];
			p30 = w[0];
			if (inv)
				w = ~w;
			for (int j = 29; j >= 0; j--) begin
				queue_bit(w[j] ^ (corrupt && n == bad_pos), (n == 0) ? t0 : $urandom);
				n++;
			end
		end
	endtask

	// Register write: a setup phase, then an access phase with penable high.
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready && addr == 3'(4 * REG_PREAMBLE))
			sync_pattern = data[7:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until the pending bits are taken and every predicted word has come out,
	// then lets a maturing candidate with bad parity finish its ring scan.
	task automatic drain;
		while (bit_queue.size() > 0 || bit_in.valid || words_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Sample both channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_taken <= 1'b0;
		end else begin
			bit_taken <= bit_in.valid && bit_in.ready;
			if (bit_in.valid && bit_in.ready) begin
				framer_predict(bit_in.nav_bit, bit_in.sample_time);
				bits_taken++;
			end
			if (word_out.valid && word_out.ready) begin
				words_taken++;
				if (words_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: index %0d bits %h", word_out.word_index,
							word_out.word_bits);
				end else begin
					nav_word_t e;
					e = words_due.pop_front();
					if (word_out.word_index !== e.idx || word_out.word_bits !== e.bits
						|| word_out.start_time !== e.st || word_out.was_inverted !== e.inv
						|| word_out.last_word !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch: expected %0d %h %h %b %b, got %0d %h %h %b %b",
								e.idx, e.bits, e.st, e.inv, e.last, word_out.word_index,
								word_out.word_bits, word_out.start_time, word_out.was_inverted,
								word_out.last_word);
					end
				end
			end
		end
	end

	// Bit request driver and word receiver, both changing at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!bit_in.valid || bit_taken) begin
				if (bit_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
					nav_bit_t it;
					it = bit_queue.pop_front();
					bit_in.valid <= 1'b1;
					bit_in.nav_bit <= it.b;
					bit_in.sample_time <= it.t;
				end else begin
					bit_in.valid <= 1'b0;
				end
			end
			word_out.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bit_in.valid && bit_in.ready) || (word_out.valid && word_out.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL nav_subframe_framer");
				$finish;
			end
		end
	end

	// Long receiver hold-off in the last phase, so the output backs up into the input.
	initial begin
		recv_hold = 1'b0;
		wait (phase == 3);
		repeat (200) @(posedge clk);
		recv_hold = 1'b1;
		repeat (3000) @(posedge clk);
		recv_hold = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		bit_in.valid = 1'b0;
		bit_in.nav_bit = 1'b0;
		bit_in.sample_time = '0;
		word_out.ready = 1'b0;
		send_idle = 31;
		recv_idle = 70;
		mismatches = 0;
		bits_taken = 0;
		words_taken = 0;
		quiet = 0;
		phase = 0;
		wr_pos = '0;
		last8 = '0;
		for (int k = 0; k < 8; k++)
			last8_times[k] = '0;
		cand_head = '0;
		cand_count = '0;
		sync_pattern = PREAMBLE_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase 0, reset pattern. The first eight bits alternate, so no early match
		// can occur before the ring holds eight real bits.
		for (int i = 0; i < 8; i++)
			queue_bit(i % 2 == 0, $urandom);
		queue_subframe(sync_pattern, 1'b0, 32'h0000_0000, 1'b0);
		queue_subframe(sync_pattern, 1'b1, 32'hFFFF_FFFF, 1'b0);
		queue_subframe(sync_pattern, 1'b0, $urandom, 1'b1);
		queue_noise(40);
		queue_subframe(sync_pattern, 1'($urandom_range(1)), $urandom, 1'b0);
		drain();

		// Phase 1, all-zero pattern: a long run of zeros fills the pending store.
		phase = 1;
		send_idle = 70;
		recv_idle = 31;
		reg_write(3'(4 * REG_PREAMBLE), 32'h0000_0000);
		for (int i = 0; i < 30; i++)
			queue_bit(1'b0, $urandom);
		queue_noise(20);
		queue_subframe(8'h00, 1'($urandom_range(1)), $urandom, 1'b0);
		queue_noise(30);
		drain();

		// Phase 2, all-ones pattern, no idling.
		phase = 2;
		send_idle = 0;
		recv_idle = 0;
		reg_write(3'(4 * REG_PREAMBLE), 32'hFFFF_FF_FF);
		queue_noise(20);
		queue_subframe(8'hFF, 1'b1, $urandom, 1'b0);
		queue_subframe(8'hFF, 1'b0, $urandom, 1'($urandom_range(1)));
		queue_noise(20);
		drain();

		// Phase 3, a random pattern, with back-to-back frames under a receiver hold-off.
		phase = 3;
		reg_write(3'(4 * REG_PREAMBLE), $urandom);
		queue_noise(15);
		for (int f = 0; f < 3; f++) begin
			queue_subframe(sync_pattern, 1'($urandom_range(1)), $urandom,
				$urandom_range(3) == 0);
			queue_noise($urandom_range(20));
		end
		drain();

		$display("Run covered %0d bits and %0d words over four sync patterns,", bits_taken,
			words_taken);
		$display("upright, inverted and corrupt subframes, a full pending store and back-pressure.");
		if (mismatches == 0 && words_due.size() == 0) begin
			$display("PASS nav_subframe_framer");
		end else begin
			$display("%0d mismatches, %0d words still expected", mismatches, words_due.size());
			$display("FAIL nav_subframe_framer");
		end
		$finish;
	end
endmodule
